FILE: sv/pqm_pkg.sv
// Package for the process queue manager: field widths, operation, status and
// queue codes, and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none
package pqm_pkg;

    localparam int MAX_PROCESSES_DEF   = 16;
    localparam int PRIORITY_LEVELS_DEF = 10;

    localparam int OP_W     = 3;
    localparam int ID_W     = 4;
    localparam int PRI_W    = 4;
    localparam int RS_W     = 2;
    localparam int QSEL_W   = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 5;
    localparam int MEM_W    = 2;

    typedef logic [OP_W-1:0]     op_code_t;
    typedef logic [STATUS_W-1:0] status_code_t;
    typedef logic [QSEL_W-1:0]   queue_t;

    localparam op_code_t OP_INSERT   = 3'd0;
    localparam op_code_t OP_REMOVE   = 3'd1;
    localparam op_code_t OP_POP_RDY  = 3'd2;
    localparam op_code_t OP_POP_SUSP = 3'd3;
    localparam op_code_t OP_APPEND   = 3'd4;
    localparam op_code_t OP_QUERY    = 3'd5;

    localparam status_code_t ST_OK       = 3'd0;
    localparam status_code_t ST_INVALID  = 3'd1;
    localparam status_code_t ST_NOTFOUND = 3'd2;
    localparam status_code_t ST_EMPTY    = 3'd3;
    localparam status_code_t ST_QUEUED   = 3'd4;

    localparam queue_t Q_READY   = 2'd0;
    localparam queue_t Q_BLOCKED = 2'd1;
    localparam queue_t Q_SUSP    = 2'd2;

    localparam logic [RS_W-1:0] RS_READY   = 2'd0;
    localparam logic [RS_W-1:0] RS_BLOCKED = 2'd1;

    localparam logic [MEM_W-1:0] MEM_NONE = 2'd0;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_START,
        CMD_STATUS,
        CMD_PUSH_TAIL,
        CMD_STEP,
        CMD_INS_PREV,
        CMD_INS_LINK,
        CMD_UNLINK,
        CMD_POP,
        CMD_EMIT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t      op;
        logic         accept;
        logic         wr_pri;
        queue_t       queue;
        status_code_t code;
    } cmd_t;

    typedef struct packed {
        logic       in_valid;
        op_code_t   op;
        logic       id_ok;
        logic       in_queue;
        queue_t     member_q;
        logic       ins_bad;
        logic       qsel_bad;
        logic       susp;
        logic       rs_ready;
        logic       sel_empty;
        logic       walk_end;
        logic       cur_is_id;
        logic       prio_after;
        logic       have_prev;
        logic       out_busy;
    } stat_t;

endpackage
`default_nettype wire

FILE: sv/pqm_req_if.sv
// Request channel of the process queue manager: valid/ready plus operation fields.
// Depends on pqm_pkg for field widths.
`default_nettype none
interface pqm_req_if;
    import pqm_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ID_W-1:0]   process_id;
    logic [PRI_W-1:0]  priority_req;
    logic [RS_W-1:0]   run_state;
    logic              is_suspended;
    logic [QSEL_W-1:0] queue_select;

    modport source (output valid, operation, process_id, priority_req, run_state,
                    is_suspended, queue_select, input ready);
    modport sink (input valid, operation, process_id, priority_req, run_state,
                  is_suspended, queue_select, output ready);
endinterface
`default_nettype wire

FILE: sv/pqm_rsp_if.sv
// Response channel of the process queue manager: valid/ready plus result fields.
// Depends on pqm_pkg for field widths.
`default_nettype none
interface pqm_rsp_if;
    import pqm_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     result_id;
    logic                result_valid;
    logic                ready_empty;
    logic                blocked_empty;
    logic                suspended_empty;
    logic [ID_W-1:0]     ready_head_id;
    logic [COUNT_W-1:0]  ready_count;
    logic [COUNT_W-1:0]  blocked_count;
    logic [COUNT_W-1:0]  suspended_count;

    modport source (output valid, status, result_id, result_valid, ready_empty,
                    blocked_empty, suspended_empty, ready_head_id, ready_count,
                    blocked_count, suspended_count, input ready);
    modport sink (input valid, status, result_id, result_valid, ready_empty,
                  blocked_empty, suspended_empty, ready_head_id, ready_count,
                  blocked_count, suspended_count, output ready);
endinterface
`default_nettype wire

FILE: sv/pqm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pqm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: sv/pqm_ctrl.sv
// Controller of the process queue manager: sequences each request through
// decode, list walk and update steps. Depends on pqm_pkg.
`default_nettype none
module pqm_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire pqm_pkg::stat_t stat,
    output pqm_pkg::cmd_t       cmd
);
    import pqm_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_DECODE   = 11'b000_0000_0010,
        S_TAIL     = 11'b000_0000_0100,
        S_WALK_INS = 11'b000_0000_1000,
        S_CMP_INS  = 11'b000_0001_0000,
        S_INS_LINK = 11'b000_0010_0000,
        S_WALK_RM  = 11'b000_0100_0000,
        S_CMP_RM   = 11'b000_1000_0000,
        S_POP_CHK  = 11'b001_0000_0000,
        S_POP_DO   = 11'b010_0000_0000,
        S_FINISH   = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '{op: CMD_NONE, accept: 1'b0, wr_pri: 1'b0, queue: Q_READY,
                       code: ST_OK};
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = 1'b1;
                if (stat.in_valid)
                begin
                    cmd.op     = CMD_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                unique case (stat.op)
                    OP_INSERT:
                    begin
                        if (!stat.id_ok || stat.ins_bad)
                        begin
                            cmd.op   = CMD_STATUS;
                            cmd.code = ST_INVALID;
                        end
                        else if (stat.in_queue)
                        begin
                            cmd.op   = CMD_STATUS;
                            cmd.code = ST_QUEUED;
                        end
                        else
                        begin
                            cmd.op     = CMD_START;
                            cmd.wr_pri = 1'b1;
                            if (stat.susp)
                            begin
                                cmd.queue  = Q_SUSP;
                                state_next = S_TAIL;
                            end
                            else if (stat.rs_ready)
                            begin
                                cmd.queue  = Q_READY;
                                state_next = S_WALK_INS;
                            end
                            else
                            begin
                                cmd.queue  = Q_BLOCKED;
                                state_next = S_TAIL;
                            end
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (!stat.id_ok || !stat.in_queue)
                        begin
                            cmd.op   = CMD_STATUS;
                            cmd.code = ST_NOTFOUND;
                        end
                        else
                        begin
                            cmd.op     = CMD_START;
                            cmd.queue  = stat.member_q;
                            state_next = S_WALK_RM;
                        end
                    end
                    OP_POP_RDY, OP_POP_SUSP:
                    begin
                        cmd.op     = CMD_START;
                        cmd.queue  = (stat.op == OP_POP_RDY) ? Q_READY : Q_SUSP;
                        state_next = S_POP_CHK;
                    end
                    OP_APPEND:
                    begin
                        if (!stat.id_ok || stat.qsel_bad)
                        begin
                            cmd.op   = CMD_STATUS;
                            cmd.code = ST_INVALID;
                        end
                        else if (stat.in_queue)
                        begin
                            cmd.op   = CMD_STATUS;
                            cmd.code = ST_QUEUED;
                        end
                        else
                        begin
                            cmd.op     = CMD_START;
                            cmd.queue  = Q_READY;
                            state_next = S_TAIL;
                        end
                    end
                    OP_QUERY:
                    begin
                        cmd.op = CMD_NONE;
                    end
                    default:
                    begin
                        cmd.op   = CMD_STATUS;
                        cmd.code = ST_INVALID;
                    end
                endcase
            end
            S_TAIL:
            begin
                cmd.op     = CMD_PUSH_TAIL;
                state_next = S_FINISH;
            end
            S_WALK_INS:
            begin
                if (stat.walk_end)
                begin
                    cmd.op     = CMD_PUSH_TAIL;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_CMP_INS;
                end
            end
            S_CMP_INS:
            begin
                if (!stat.prio_after)
                begin
                    cmd.op     = CMD_STEP;
                    state_next = S_WALK_INS;
                end
                else if (stat.have_prev)
                begin
                    cmd.op     = CMD_INS_PREV;
                    state_next = S_INS_LINK;
                end
                else
                begin
                    cmd.op     = CMD_INS_LINK;
                    state_next = S_FINISH;
                end
            end
            S_INS_LINK:
            begin
                cmd.op     = CMD_INS_LINK;
                state_next = S_FINISH;
            end
            S_WALK_RM:
            begin
                if (stat.walk_end)
                begin
                    cmd.op     = CMD_STATUS;
                    cmd.code   = ST_NOTFOUND;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_CMP_RM;
                end
            end
            S_CMP_RM:
            begin
                if (stat.cur_is_id)
                begin
                    cmd.op     = CMD_UNLINK;
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.op     = CMD_STEP;
                    state_next = S_WALK_RM;
                end
            end
            S_POP_CHK:
            begin
                if (stat.sel_empty)
                begin
                    cmd.op     = CMD_STATUS;
                    cmd.code   = ST_EMPTY;
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_POP_DO;
                end
            end
            S_POP_DO:
            begin
                cmd.op     = CMD_POP;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the output register frees up
                if (!stat.out_busy)
                begin
                    cmd.op     = CMD_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

FILE: sv/pqm_dp.sv
// Datapath of the process queue manager: queue registers, membership table,
// link and priority RAMs, request capture and the output register.
// Depends on pqm_pkg, pqm_ram, pqm_req_if and pqm_rsp_if.
`default_nettype none
module pqm_dp #(
    parameter int MAX_PROCESSES   = pqm_pkg::MAX_PROCESSES_DEF,
    parameter int PRIORITY_LEVELS = pqm_pkg::PRIORITY_LEVELS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    pqm_req_if.sink            req,
    pqm_rsp_if.source          rsp,
    input  wire pqm_pkg::cmd_t cmd,
    output pqm_pkg::stat_t     stat
);
    import pqm_pkg::*;

    localparam int SLOT_W = $clog2(MAX_PROCESSES);
    localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
    localparam logic [PRI_W-1:0] PRI_MAX = PRI_W'(PRIORITY_LEVELS - 1);

    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    op_code_t          op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [PRI_W-1:0]  pri_reg;
    logic [RS_W-1:0]   rs_reg;
    logic              susp_reg;
    logic [QSEL_W-1:0] qsel_reg;

    queue_t       q_reg;
    slot_t        cur_reg;
    slot_t        prev_reg;
    logic         have_prev_reg;
    cnt_t         walk_reg;
    status_code_t res_status_reg;
    logic [ID_W-1:0] res_id_reg;
    logic         res_valid_reg;

    slot_t             head_reg  [3];
    slot_t             tail_reg  [3];
    cnt_t              count_reg [3];
    logic [MEM_W-1:0]  member_reg [MAX_PROCESSES];

    logic                out_valid_reg;
    status_code_t        o_status_reg;
    logic [ID_W-1:0]     o_id_reg;
    logic                o_valid_reg;
    logic [ID_W-1:0]     o_head_reg;
    logic [COUNT_W-1:0]  o_count_reg [3];

    slot_t            sid;
    logic [MEM_W-1:0] member_rd;
    slot_t            link_rd;
    logic [PRI_W-1:0] prio_rd;
    logic             link_we;
    slot_t            link_waddr;
    slot_t            link_wdata;
    logic             prio_we;
    logic             id_ok;

    assign sid       = SLOT_W'(id_reg);
    assign id_ok     = 32'(id_reg) < MAX_PROCESSES;
    assign member_rd = member_reg[sid];

    always_comb
    begin
        link_we     = 1'b0;
        link_waddr  = prev_reg;
        link_wdata  = sid;
        case (cmd.op)
            CMD_PUSH_TAIL:
            begin
                link_we    = count_reg[q_reg] != '0;
                link_waddr = tail_reg[q_reg];
            end
            CMD_INS_PREV:
            begin
                link_we = 1'b1;
            end
            CMD_INS_LINK:
            begin
                link_we    = 1'b1;
                link_waddr = sid;
                link_wdata = cur_reg;
            end
            CMD_UNLINK:
            begin
                link_we    = have_prev_reg;
                link_wdata = link_rd;
            end
            default:
            begin
                link_we = 1'b0;
            end
        endcase
    end

    assign prio_we = (cmd.op == CMD_START) && cmd.wr_pri;

    pqm_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_PROCESSES)) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (cur_reg),
        .rdata (link_rd)
    );

    pqm_ram #(.WIDTH(PRI_W), .DEPTH(MAX_PROCESSES)) u_prio_ram (
        .clk   (clk),
        .we    (prio_we),
        .waddr (sid),
        .wdata (pri_reg),
        .raddr (cur_reg),
        .rdata (prio_rd)
    );

    always_comb
    begin
        stat.in_valid   = req.valid;
        stat.op         = op_reg;
        stat.id_ok      = id_ok;
        stat.in_queue   = member_rd != MEM_NONE;
        stat.member_q   = queue_t'(member_rd - 2'd1);
        stat.ins_bad    = !susp_reg && (rs_reg != RS_READY) && (rs_reg != RS_BLOCKED);
        stat.qsel_bad   = (qsel_reg != Q_READY) && (qsel_reg != Q_BLOCKED)
                          && (qsel_reg != Q_SUSP);
        stat.susp       = susp_reg;
        stat.rs_ready   = rs_reg == RS_READY;
        stat.sel_empty  = count_reg[q_reg] == '0;
        stat.walk_end   = walk_reg == count_reg[q_reg];
        stat.cur_is_id  = cur_reg == sid;
        stat.prio_after = prio_rd > pri_reg;
        stat.have_prev  = have_prev_reg;
        stat.out_busy   = out_valid_reg && !rsp.ready;
    end

    assign req.ready = cmd.accept;

    // request capture and walk registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            CMD_LOAD:
            begin
                op_reg         <= req.operation;
                id_reg         <= req.process_id;
                pri_reg        <= (req.priority_req > PRI_MAX) ? PRI_MAX : req.priority_req;
                rs_reg         <= req.run_state;
                susp_reg       <= req.is_suspended;
                qsel_reg       <= req.queue_select;
                res_status_reg <= ST_OK;
                res_id_reg     <= '0;
                res_valid_reg  <= 1'b0;
            end
            CMD_START:
            begin
                q_reg         <= (op_reg == OP_APPEND) ? qsel_reg : cmd.queue;
                cur_reg       <= head_reg[(op_reg == OP_APPEND) ? qsel_reg : cmd.queue];
                prev_reg      <= '0;
                have_prev_reg <= 1'b0;
                walk_reg      <= '0;
            end
            CMD_STATUS:
            begin
                res_status_reg <= cmd.code;
            end
            CMD_STEP:
            begin
                prev_reg      <= cur_reg;
                have_prev_reg <= 1'b1;
                cur_reg       <= link_rd;
                walk_reg      <= walk_reg + cnt_t'(1);
            end
            CMD_POP:
            begin
                res_id_reg    <= ID_W'(cur_reg);
                res_valid_reg <= 1'b1;
            end
            default:
            begin
                res_valid_reg <= res_valid_reg;
            end
        endcase
    end

    // queue state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                head_reg[k]  <= '0;
                tail_reg[k]  <= '0;
                count_reg[k] <= '0;
            end
            for (int k = 0; k < MAX_PROCESSES; k++)
            begin
                member_reg[k] <= MEM_NONE;
            end
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // load on emit, otherwise hold until the receiver takes it
            out_valid_reg <= (cmd.op == CMD_EMIT) || (out_valid_reg && !rsp.ready);
            case (cmd.op)
                CMD_PUSH_TAIL:
                begin
                    if (count_reg[q_reg] == '0)
                    begin
                        head_reg[q_reg] <= sid;
                    end
                    tail_reg[q_reg]  <= sid;
                    count_reg[q_reg] <= count_reg[q_reg] + cnt_t'(1);
                    member_reg[sid]  <= MEM_W'(q_reg + 2'd1);
                end
                CMD_INS_LINK:
                begin
                    if (!have_prev_reg)
                    begin
                        head_reg[q_reg] <= sid;
                    end
                    count_reg[q_reg] <= count_reg[q_reg] + cnt_t'(1);
                    member_reg[sid]  <= MEM_W'(q_reg + 2'd1);
                end
                CMD_UNLINK:
                begin
                    if (!have_prev_reg)
                    begin
                        head_reg[q_reg] <= link_rd;
                    end
                    if (cur_reg == tail_reg[q_reg])
                    begin
                        tail_reg[q_reg] <= have_prev_reg ? prev_reg : '0;
                    end
                    count_reg[q_reg] <= count_reg[q_reg] - cnt_t'(1);
                    if (count_reg[q_reg] == cnt_t'(1))
                    begin
                        head_reg[q_reg] <= '0;
                        tail_reg[q_reg] <= '0;
                    end
                    member_reg[cur_reg] <= MEM_NONE;
                end
                CMD_POP:
                begin
                    head_reg[q_reg]  <= link_rd;
                    count_reg[q_reg] <= count_reg[q_reg] - cnt_t'(1);
                    if (count_reg[q_reg] == cnt_t'(1))
                    begin
                        head_reg[q_reg] <= '0;
                        tail_reg[q_reg] <= '0;
                    end
                    member_reg[cur_reg] <= MEM_NONE;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == CMD_EMIT)
        begin
            o_status_reg <= res_status_reg;
            o_id_reg     <= res_id_reg;
            o_valid_reg  <= res_valid_reg;
            o_head_reg   <= (count_reg[Q_READY] == '0) ? '0 : ID_W'(head_reg[Q_READY]);
            for (int k = 0; k < 3; k++)
            begin
                o_count_reg[k] <= COUNT_W'(count_reg[k]);
            end
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = o_status_reg;
    assign rsp.result_id       = o_id_reg;
    assign rsp.result_valid    = o_valid_reg;
    assign rsp.ready_head_id   = o_head_reg;
    assign rsp.ready_count     = o_count_reg[Q_READY];
    assign rsp.blocked_count   = o_count_reg[Q_BLOCKED];
    assign rsp.suspended_count = o_count_reg[Q_SUSP];
    assign rsp.ready_empty     = o_count_reg[Q_READY] == '0;
    assign rsp.blocked_empty   = o_count_reg[Q_BLOCKED] == '0;
    assign rsp.suspended_empty = o_count_reg[Q_SUSP] == '0;
endmodule
`default_nettype wire

FILE: sv/process_queue_manager_top.sv
// Process queue manager: three linked queues (ready by priority, blocked and
// suspended FIFO) of process slots, one response per request.
//
// Channels: req carries one command (insert, remove, pop ready, pop suspended,
// append, query); rsp returns status, popped slot, empty flags, counts and
// the ready head after the command has taken effect. Both use valid/ready.
// Steps: query and rejected commands go from decode straight to finish;
// append, blocked or suspended insert add a tail push, pops an empty check
// and a pop; ready insert and remove walk the list with a walk and a compare
// state per visited entry (link/priority RAM read, compare). One request is
// worked at a time; req.ready rises in the same cycle as rsp.valid.
// The response sits in an output register, so a new request is taken while it
// waits; if the receiver stalls, the next response holds in the controller
// until the register is emptied.
// Reset clears all queues and membership; the link and priority RAMs are not
// cleared by reset.
// Depends on pqm_pkg, pqm_req_if, pqm_rsp_if, pqm_ram, pqm_ctrl and pqm_dp.
`default_nettype none
module process_queue_manager_top #(
    parameter int MAX_PROCESSES   = pqm_pkg::MAX_PROCESSES_DEF,
    parameter int PRIORITY_LEVELS = pqm_pkg::PRIORITY_LEVELS_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    pqm_req_if.sink   req,
    pqm_rsp_if.source rsp
);
    import pqm_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    pqm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    pqm_dp #(
        .MAX_PROCESSES   (MAX_PROCESSES),
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cmd   (cmd),
        .stat  (stat)
    );
endmodule
`default_nettype wire
